>>> src/smpc_pkg.sv
// Shared types, register codes and constants of the soil moisture pump controller.
package smpc_pkg;

  localparam int DIV_NUM_W = 18;  // magnitude of (average - dry) * 100
  localparam int DIV_DEN_W = 10;  // magnitude of (wet - dry), also holds the sample count
  localparam int SUM_W     = 14;
  localparam int RAW_W     = 10;
  localparam int PCT_W     = 7;
  localparam int MS_W      = 32;
  localparam int CFG_W     = 32;
  localparam int IDX_W     = 3;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  localparam logic [RAW_W-1:0] DRY_RAW_RST       = 10'd970;
  localparam logic [RAW_W-1:0] WET_RAW_RST       = 10'd746;
  localparam logic [PCT_W-1:0] START_PERCENT_RST = 7'd35;
  localparam logic [PCT_W-1:0] STOP_PERCENT_RST  = 7'd60;
  localparam logic [RAW_W-1:0] FAULT_LEVEL_RST   = 10'd600;
  localparam logic [MS_W-1:0]  PULSE_MS_RST      = 32'd3000;
  localparam logic [MS_W-1:0]  SOAK_MS_RST       = 32'd5000;

  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_DRY_RAW       = 3'd0,
    REG_WET_RAW       = 3'd1,
    REG_START_PERCENT = 3'd2,
    REG_STOP_PERCENT  = 3'd3,
    REG_FAULT_LEVEL   = 3'd4,
    REG_PULSE_MS      = 3'd5,
    REG_SOAK_MS       = 3'd6
  } smpc_reg_t;

  typedef struct packed {
    logic [RAW_W-1:0] dry_raw;
    logic [RAW_W-1:0] wet_raw;
    logic [PCT_W-1:0] start_percent;
    logic [PCT_W-1:0] stop_percent;
    logic [RAW_W-1:0] fault_level;
    logic [MS_W-1:0]  pulse_ms;
    logic [MS_W-1:0]  soak_ms;
  } smpc_cfg_t;

  typedef struct packed {
    logic             req_type;
    logic [RAW_W-1:0] sample_value;
  } smpc_in_t;

  typedef struct packed {
    logic             reading_done;
    logic             pump_running;
    logic             watering_active;
    logic             sensor_fault;
    logic [PCT_W-1:0] moisture_percent;
    logic [RAW_W-1:0] average_raw;
  } smpc_out_t;

endpackage

>>> src/soil_moisture_pump_controller_top.sv
// Top level of the soil moisture pump controller: sequencer, state and result register.
//
// Usage:
//   in channel (in_valid/in_ready/in_data) carries one request per item: a
//   millisecond tick or one raw 10-bit sensor sample. out channel
//   (out_valid/out_ready/out_data) returns exactly one status request per
//   input request, in order.
//   cfg_we/cfg_index/cfg_data write the calibration, threshold and timing
//   registers; write them only while the block is idle.
//   Ticks and samples that do not finish an average are answered in the cycle
//   after acceptance. The sample that completes a group of SAMPLES runs through
//   the shared divider for the average and then, unless the calibration
//   points are equal, for the percent; in_ready stays low until its result
//   is registered.
//   The output register frees the input side: a new request is taken in the
//   cycle the pending result is drained. When out_ready stays low the block
//   holds its result and stops accepting.
//   Reset (rst, synchronous) restores the register defaults, zeroes the clock,
//   sample accumulator and status, and turns the pump off.
module soil_moisture_pump_controller_top #(
  parameter int SAMPLES = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  smpc_pkg::smpc_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output smpc_pkg::smpc_out_t           out_data,
  input  logic                          cfg_we,
  input  logic [smpc_pkg::IDX_W-1:0]    cfg_index,
  input  logic [smpc_pkg::CFG_W-1:0]    cfg_data
);
  import smpc_pkg::*;

  localparam int CNT_W = $clog2(SAMPLES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AVG_DIV,
    S_MAP,
    S_PCT_DIV,
    S_DECIDE
  } state_t;

  state_t              state;
  smpc_cfg_t           cfg;

  // controller state
  logic [MS_W-1:0]     ms_count;
  logic [MS_W-1:0]     pulse_start;
  logic [MS_W-1:0]     pulse_stop;
  logic                pump;
  logic                watering;
  logic [SUM_W-1:0]    sample_sum;
  logic [CNT_W-1:0]    sample_index;
  logic [RAW_W-1:0]    last_average;
  logic [PCT_W-1:0]    last_percent;
  logic                last_fault;
  logic                quot_neg;

  // divider hookup
  logic                    div_start;
  logic [DIV_NUM_W-1:0]    div_dividend;
  logic [DIV_DEN_W-1:0]    div_divisor;
  logic                    div_done;
  logic [DIV_NUM_W-1:0]    div_quotient;

  logic                    accept;
  logic                    out_free;
  logic [SUM_W-1:0]        sum_next;
  logic [CNT_W-1:0]        index_next;
  logic                    group_done;

  // linear map operands
  logic signed [RAW_W:0]       avg_diff;
  logic signed [RAW_W:0]       cal_diff;
  logic signed [DIV_NUM_W-1:0] num;
  logic [DIV_NUM_W-1:0]        num_mag;
  logic [DIV_DEN_W-1:0]        den_mag;

  // decision
  logic                watering_next;
  logic                pump_next;
  logic                pump_stop;
  logic                pump_start;
  logic [MS_W-1:0]     run_time;
  logic [MS_W-1:0]     rest_time;

  smpc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  smpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  assign sum_next   = sample_sum + SUM_W'(in_data.sample_value);
  assign index_next = sample_index + 1'b1;
  assign group_done = index_next >= CNT_W'(SAMPLES);

  // (avg - dry) * 100 as shift-and-add, then sign and magnitude
  always_comb begin
    avg_diff = $signed({1'b0, last_average}) - $signed({1'b0, cfg.dry_raw});
    cal_diff = $signed({1'b0, cfg.wet_raw}) - $signed({1'b0, cfg.dry_raw});
    num      = (DIV_NUM_W'(avg_diff) <<< 6) + (DIV_NUM_W'(avg_diff) <<< 5)
             + (DIV_NUM_W'(avg_diff) <<< 2);
    num_mag  = num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : DIV_NUM_W'(num);
    den_mag  = cal_diff[RAW_W] ? DIV_DEN_W'(-cal_diff) : DIV_DEN_W'(cal_diff);
  end

  // one divider serves both the averaging and the percent mapping
  always_comb begin
    div_start    = 1'b0;
    div_dividend = num_mag;
    div_divisor  = den_mag;
    if (state == S_IDLE) begin
      div_start    = accept && (in_data.req_type == REQ_SAMPLE) && group_done;
      div_dividend = DIV_NUM_W'(sum_next);
      div_divisor  = DIV_DEN_W'(SAMPLES);
    end else if (state == S_MAP) begin
      div_start    = cal_diff != '0;
    end
  end

  // hysteresis and pulse/soak timing; timestamps wrap modulo 2^32
  always_comb begin
    run_time  = ms_count - pulse_start;
    rest_time = ms_count - pulse_stop;
    if (last_fault) begin
      watering_next = 1'b0;
    end else if (!watering && (last_percent < cfg.start_percent)) begin
      watering_next = 1'b1;
    end else if (watering && (last_percent >= cfg.stop_percent)) begin
      watering_next = 1'b0;
    end else begin
      watering_next = watering;
    end
    pump_stop  = pump && (!watering_next || (run_time >= cfg.pulse_ms));
    pump_start = !pump && watering_next && (rest_time >= cfg.soak_ms);
    pump_next  = (pump && !pump_stop) || pump_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      ms_count     <= '0;
      pulse_start  <= '0;
      pulse_stop   <= '0;
      pump         <= 1'b0;
      watering     <= 1'b0;
      sample_sum   <= '0;
      sample_index <= '0;
      last_average <= '0;
      last_percent <= '0;
      last_fault   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_data.req_type == REQ_TICK) begin
              ms_count <= ms_count + 1'b1;
              out_valid <= 1'b1;
              out_data  <= '{reading_done: 1'b0, pump_running: pump,
                             watering_active: watering, sensor_fault: last_fault,
                             moisture_percent: last_percent, average_raw: last_average};
            end else if (group_done) begin
              sample_sum   <= '0;
              sample_index <= '0;
              state        <= S_AVG_DIV;
            end else begin
              sample_sum   <= sum_next;
              sample_index <= index_next;
              out_valid    <= 1'b1;
              out_data     <= '{reading_done: 1'b0, pump_running: pump,
                                watering_active: watering, sensor_fault: last_fault,
                                moisture_percent: last_percent,
                                average_raw: last_average};
            end
          end
        end
        S_AVG_DIV: begin
          if (div_done) begin
            last_average <= div_quotient[RAW_W-1:0];
            state        <= S_MAP;
          end
        end
        S_MAP: begin
          last_fault <= last_average < cfg.fault_level;
          quot_neg   <= num[DIV_NUM_W-1] ^ cal_diff[RAW_W];
          if (cal_diff == '0) begin
            // equal calibration points: percent forced to zero
            last_percent <= '0;
            state        <= S_DECIDE;
          end else begin
            state <= S_PCT_DIV;
          end
        end
        S_PCT_DIV: begin
          if (div_done) begin
            if (quot_neg) begin
              last_percent <= '0;
            end else if (div_quotient > DIV_NUM_W'(PCT_FULL)) begin
              last_percent <= PCT_FULL;
            end else begin
              last_percent <= div_quotient[PCT_W-1:0];
            end
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            watering <= watering_next;
            pump     <= pump_next;
            if (pump_stop) begin
              pulse_stop <= ms_count;
            end
            if (pump_start) begin
              pulse_start <= ms_count;
            end
            out_valid <= 1'b1;
            out_data  <= '{reading_done: 1'b1, pump_running: pump_next,
                           watering_active: watering_next, sensor_fault: last_fault,
                           moisture_percent: last_percent, average_raw: last_average};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/smpc_regs.sv
// Calibration and timing register file, written through a plain write port.
module smpc_regs (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [smpc_pkg::IDX_W-1:0]             cfg_index,
  input  logic [smpc_pkg::CFG_W-1:0]             cfg_data,
  output smpc_pkg::smpc_cfg_t                    cfg
);
  import smpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dry_raw       <= DRY_RAW_RST;
      cfg.wet_raw       <= WET_RAW_RST;
      cfg.start_percent <= START_PERCENT_RST;
      cfg.stop_percent  <= STOP_PERCENT_RST;
      cfg.fault_level   <= FAULT_LEVEL_RST;
      cfg.pulse_ms      <= PULSE_MS_RST;
      cfg.soak_ms       <= SOAK_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DRY_RAW:       cfg.dry_raw       <= cfg_data[RAW_W-1:0];
        REG_WET_RAW:       cfg.wet_raw       <= cfg_data[RAW_W-1:0];
        REG_START_PERCENT: cfg.start_percent <= cfg_data[PCT_W-1:0];
        REG_STOP_PERCENT:  cfg.stop_percent  <= cfg_data[PCT_W-1:0];
        REG_FAULT_LEVEL:   cfg.fault_level   <= cfg_data[RAW_W-1:0];
        REG_PULSE_MS:      cfg.pulse_ms      <= cfg_data[MS_W-1:0];
        REG_SOAK_MS:       cfg.soak_ms       <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/smpc_div.sv
// Shared restoring divider, one quotient bit per cycle.
module smpc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [smpc_pkg::DIV_NUM_W-1:0]    dividend,
  input  logic [smpc_pkg::DIV_DEN_W-1:0]    divisor,
  output logic                              done,
  output logic [smpc_pkg::DIV_NUM_W-1:0]    quotient
);
  import smpc_pkg::*;

  localparam int STEP_W = $clog2(DIV_NUM_W);

  logic                 busy;
  logic [STEP_W-1:0]    count;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  always_comb begin
    trial = {rem, quotient[DIV_NUM_W-1]};
    diff  = trial - {1'b0, den};
    fits  = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == STEP_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quotient <= {quotient[DIV_NUM_W-2:0], fits};
    end
  end

endmodule

>>> sim/soil_moisture_pump_controller_top_test.sv
// Self-checking testbench for the soil moisture pump controller top level.
module soil_moisture_pump_controller_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import smpc_pkg::*;

  // Samples per averaged reading; the DUT gets the same value.
  localparam int GROUP_SIZE      = 10;
  localparam int FULL_SCALE      = int'(PCT_FULL);
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 254;
  localparam int STALL_CYCLES    = 300;  // one long receiver hold-off
  localparam int TAIL_CYCLES     = 60;
  localparam int CYCLE_LIMIT     = 300000;

  // Where a directed row gets its expected status from.
  typedef enum bit {
    CHECK_PREDICTED,
    CHECK_TYPED
  } check_src_t;

  // One directed row: the same request sent reps times.
  typedef struct packed {
    smpc_in_t   item;
    logic [4:0] reps;
    check_src_t source;
    smpc_out_t  result;
  } script_row_t;

  localparam int SCRIPT_ROWS = 7;

  // Reset calibration: dry 970, wet 746, start 35, stop 60, fault 600, soak 5000 ms.
  // Ten samples at full scale read as very dry (clamped to 0 percent), which
  // starts a watering cycle; the pump stays off because the soak time since
  // reset has not passed. Ten zero samples then fall below the fault level:
  // fault set, watering dropped, percent clamped at the top.
  script_row_t script [SCRIPT_ROWS] = '{
    '{'{REQ_TICK,   10'd0},    5'd1, CHECK_TYPED,
      '{1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 10'd0}},
    '{'{REQ_SAMPLE, 10'd1023}, 5'd9, CHECK_TYPED,
      '{1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 10'd0}},
    '{'{REQ_SAMPLE, 10'd1023}, 5'd1, CHECK_TYPED,
      '{1'b1, 1'b0, 1'b1, 1'b0, 7'd0, 10'd1023}},
    '{'{REQ_SAMPLE, 10'd0},    5'd9, CHECK_TYPED,
      '{1'b0, 1'b0, 1'b1, 1'b0, 7'd0, 10'd1023}},
    '{'{REQ_SAMPLE, 10'd0},    5'd1, CHECK_TYPED,
      '{1'b1, 1'b0, 1'b0, 1'b1, PCT_FULL, 10'd0}},
    '{'{REQ_TICK,   10'd0},    5'd1, CHECK_TYPED,
      '{1'b0, 1'b0, 1'b0, 1'b1, PCT_FULL, 10'd0}},
    // partial group, carried on into the random part
    '{'{REQ_SAMPLE, 10'd512},  5'd3, CHECK_PREDICTED, '0}
  };

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  smpc_in_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  smpc_out_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data  = '0;

  // Predicted controller: configuration and state mirror.
  smpc_cfg_t           cal;
  logic [MS_W-1:0]     ms_clock;
  logic [MS_W-1:0]     pulse_on_at;
  logic [MS_W-1:0]     pulse_off_at;
  logic                pump_on;
  logic                watering;
  logic [SUM_W-1:0]    acc_sum;
  logic [3:0]          acc_count;
  logic [RAW_W-1:0]    avg_hold;
  logic [PCT_W-1:0]    pct_hold;
  logic                fault_hold;

  smpc_out_t           pending_status [$];  // expected status, oldest first
  int                  error_count = 0;
  int                  cycle_count = 0;
  int                  group_level = 0;     // sample level of the current group
  bit                  sender_gaps = 1'b1;
  bit                  receiver_gaps = 1'b1;
  bit                  hold_off_request = 1'b0;

  soil_moisture_pump_controller_top #(
    .SAMPLES(GROUP_SIZE)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: a hang or a lost result ends here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [RAW_W-1:0] clamp_raw(int v);
    if (v < 0) return '0;
    if (v > 1023) return '1;
    return RAW_W'(v);
  endfunction

  // Advances the predicted controller by one request and returns its status.
  function automatic smpc_out_t advance_controller(smpc_in_t item);
    smpc_out_t       r;
    logic [MS_W-1:0] since;
    int              span;
    int              pct;
    r.reading_done = 1'b0;
    if (item.req_type == REQ_TICK) begin
      ms_clock = ms_clock + 1'b1;
    end else begin
      acc_sum   = acc_sum + SUM_W'(item.sample_value);  // wraps at the accumulator width
      acc_count = acc_count + 1'b1;
      if (int'(acc_count) >= GROUP_SIZE) begin
        avg_hold   = RAW_W'(acc_sum / GROUP_SIZE);
        acc_sum    = '0;
        acc_count  = '0;
        fault_hold = avg_hold < cal.fault_level;
        // linear map dry -> 0, wet -> 100; truncate toward zero, then clamp
        span = int'(cal.wet_raw) - int'(cal.dry_raw);
        if (span == 0) begin
          pct = 0;
        end else begin
          pct = ((int'(avg_hold) - int'(cal.dry_raw)) * FULL_SCALE) / span;
        end
        if (pct < 0) pct = 0;
        if (pct > FULL_SCALE) pct = FULL_SCALE;
        pct_hold = PCT_W'(pct);
        // hysteresis; a fault always ends watering
        if (fault_hold) begin
          watering = 1'b0;
        end else if (!watering && pct_hold < cal.start_percent) begin
          watering = 1'b1;
        end else if (watering && pct_hold >= cal.stop_percent) begin
          watering = 1'b0;
        end
        // pulse / soak timing on wrapping timestamps
        if (pump_on) begin
          since = ms_clock - pulse_on_at;
          if (!watering || since >= cal.pulse_ms) begin
            pump_on      = 1'b0;
            pulse_off_at = ms_clock;
          end
        end else begin
          since = ms_clock - pulse_off_at;
          if (watering && since >= cal.soak_ms) begin
            pump_on     = 1'b1;
            pulse_on_at = ms_clock;
          end
        end
        r.reading_done = 1'b1;
      end
    end
    r.pump_running     = pump_on;
    r.watering_active  = watering;
    r.sensor_fault     = fault_hold;
    r.moisture_percent = pct_hold;
    r.average_raw      = avg_hold;
    return r;
  endfunction

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      error_count++;
    end
  endfunction

  // Offers one request, holding valid until it is taken, and records what
  // should come back. A random gap may precede it.
  task automatic offer(smpc_in_t item, check_src_t source, smpc_out_t typed);
    smpc_out_t predicted;
    if (sender_gaps && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    predicted = advance_controller(item);
    pending_status.push_back(source == CHECK_TYPED ? typed : predicted);
  endtask

  // Sender goes quiet until every outstanding result has been collected.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only called while idle; the mirror masks to the register width like the DUT.
  task automatic write_register(smpc_reg_t index, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    case (index)
      REG_DRY_RAW:       cal.dry_raw       = value[RAW_W-1:0];
      REG_WET_RAW:       cal.wet_raw       = value[RAW_W-1:0];
      REG_START_PERCENT: cal.start_percent = value[PCT_W-1:0];
      REG_STOP_PERCENT:  cal.stop_percent  = value[PCT_W-1:0];
      REG_FAULT_LEVEL:   cal.fault_level   = value[RAW_W-1:0];
      REG_PULSE_MS:      cal.pulse_ms      = value;
      REG_SOAK_MS:       cal.soak_ms       = value;
      default: ;
    endcase
  endtask

  // Result side: checks every status that is taken, throttles out_ready at
  // random, and serves one long hold-off on request so the block backs up.
  initial begin : result_side
    int        stall_left;
    smpc_out_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_status.size() == 0) begin
          $error("unexpected status request: %p", out_data);
          error_count++;
        end else begin
          want = pending_status.pop_front();
          compare_field("reading_done", 32'(want.reading_done),
                        32'(out_data.reading_done));
          compare_field("pump_running", 32'(want.pump_running),
                        32'(out_data.pump_running));
          compare_field("watering_active", 32'(want.watering_active),
                        32'(out_data.watering_active));
          compare_field("sensor_fault", 32'(want.sensor_fault),
                        32'(out_data.sensor_fault));
          compare_field("moisture_percent", 32'(want.moisture_percent),
                        32'(out_data.moisture_percent));
          compare_field("average_raw", 32'(want.average_raw),
                        32'(out_data.average_raw));
        end
      end
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        stall_left       = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !receiver_gaps || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  initial begin : request_side
    smpc_cfg_t setting;
    smpc_in_t  item;
    int        lo;
    int        hi;
    int        jitter;

    // mirror comes up in its reset state
    cal          = '{DRY_RAW_RST, WET_RAW_RST, START_PERCENT_RST, STOP_PERCENT_RST,
                     FAULT_LEVEL_RST, PULSE_MS_RST, SOAK_MS_RST};
    ms_clock     = '0;
    pulse_on_at  = '0;
    pulse_off_at = '0;
    pump_on      = 1'b0;
    watering     = 1'b0;
    acc_sum      = '0;
    acc_count    = '0;
    avg_hold     = '0;
    pct_hold     = '0;
    fault_hold   = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, reset calibration.
    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      for (int k = 0; k < int'(script[r].reps); k++) begin
        offer(script[r].item, script[r].source, script[r].result);
      end
    end

    // Random part, one calibration per phase.
    for (int phase = 0; phase < PHASES; phase++) begin
      settle_idle();
      case (phase)
        // stock calibration, short pulse/soak so the pump cycles often
        0: setting = '{10'd970, 10'd746, 7'd35, 7'd60, 10'd600, 32'd25, 32'd40};
        // full-range calibration, zero fault level, zero timing
        1: setting = '{10'd0, 10'd1023, 7'd100, 7'd100, 10'd0, 32'd0, 32'd0};
        // inverted full range, top fault level, longest timing
        2: setting = '{10'd1023, 10'd0, 7'd0, 7'd0, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        // equal calibration (percent stuck at 0), start threshold above 100
        3: setting = '{10'd500, 10'd500, 7'd127, 7'd0, 10'd300, 32'd10, 32'd10};
        4: begin
          setting.dry_raw       = RAW_W'($urandom_range(700, 1023));
          setting.wet_raw       = RAW_W'($urandom_range(150, 690));
          setting.start_percent = PCT_W'($urandom_range(10, 60));
          setting.stop_percent  = PCT_W'(setting.start_percent + $urandom_range(0, 40));
          setting.fault_level   = RAW_W'($urandom_range(0, 500));
          setting.pulse_ms      = $urandom_range(1, 60);
          setting.soak_ms       = $urandom_range(1, 80);
        end
        default: begin
          setting.dry_raw       = RAW_W'($urandom);
          setting.wet_raw       = RAW_W'($urandom);
          setting.start_percent = PCT_W'($urandom);
          setting.stop_percent  = PCT_W'($urandom);
          setting.fault_level   = RAW_W'($urandom_range(0, 700));
          setting.pulse_ms      = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 80);
          setting.soak_ms       = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 80);
        end
      endcase
      // narrow registers get junk above their width; the DUT must drop it
      write_register(REG_DRY_RAW,       ($urandom << RAW_W) | CFG_W'(setting.dry_raw));
      write_register(REG_WET_RAW,       ($urandom << RAW_W) | CFG_W'(setting.wet_raw));
      write_register(REG_START_PERCENT, ($urandom << PCT_W) | CFG_W'(setting.start_percent));
      write_register(REG_STOP_PERCENT,  ($urandom << PCT_W) | CFG_W'(setting.stop_percent));
      write_register(REG_FAULT_LEVEL,   ($urandom << RAW_W) | CFG_W'(setting.fault_level));
      write_register(REG_PULSE_MS,      setting.pulse_ms);
      write_register(REG_SOAK_MS,       setting.soak_ms);
      cfg_we <= 1'b0;

      // phase 1 runs flat out on both sides; phase 2 opens with a long
      // receiver stall while requests keep coming
      sender_gaps   = (phase != 1);
      receiver_gaps = (phase != 1);
      if (phase == 2) hold_off_request = 1'b1;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // halfway through phase 3 the sender waits for a full drain
        if (phase == 3 && n == ITEMS_PER_PHASE / 2) settle_idle();
        item.req_type     = ($urandom_range(0, 99) < 55) ? REQ_TICK : REQ_SAMPLE;
        item.sample_value = RAW_W'($urandom);  // don't-care on ticks
        if (item.req_type == REQ_SAMPLE) begin
          // samples of one group cluster around a level so that averages
          // sweep the calibrated span, the fault level and the odd outlier
          if (acc_count == '0) begin
            lo = int'((cal.dry_raw < cal.wet_raw) ? cal.dry_raw : cal.wet_raw);
            hi = int'((cal.dry_raw < cal.wet_raw) ? cal.wet_raw : cal.dry_raw);
            case ($urandom_range(0, 4))
              0: group_level = $urandom_range(0, 1023);
              1: group_level = int'(clamp_raw(int'(cal.fault_level)
                                              + int'($urandom_range(0, 20)) - 10));
              default: group_level = $urandom_range(32'(clamp_raw(hi + 40)),
                                                    32'(clamp_raw(lo - 40)));
            endcase
          end
          jitter = $urandom_range(0, 16);
          item.sample_value = clamp_raw(group_level + jitter - 8);
        end
        offer(item, CHECK_PREDICTED, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
